FILE: hw/rtl/abbf_pkg.sv
// ============================================================================
// abbf_pkg - shared definitions for the absolute binary block framer
// Field widths, command and status codes, header layout and ALU opcodes.
// ============================================================================
`default_nettype none

package abbf_pkg;

  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 2;

  // Default largest block, in data words
  localparam int MAX_BLOCK_WORDS = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

  // Result status
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ORDER = 1'b1;

  // Header: four zero bytes, count word, address word, checksum word
  localparam int HDR_BYTES  = 10;
  localparam int LEAD_ZEROS = 4;
  localparam int HIDX_W     = $clog2(HDR_BYTES);
  localparam logic [HIDX_W-1:0] HDR_LAST = HIDX_W'(HDR_BYTES - 1);

  // Shared arithmetic unit operations
  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_INC,
    ALU_NEG
  } alu_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/abbf_in_if.sv
// ============================================================================
// abbf_in_if - input item channel
// Valid/ready channel carrying one command, address and data word.
// ============================================================================
`default_nettype none

interface abbf_in_if;
  logic                          valid;
  logic                          ready;
  logic [abbf_pkg::CMD_W-1:0]    cmd;
  logic [abbf_pkg::WORD_W-1:0]   address;
  logic [abbf_pkg::WORD_W-1:0]   data;

  modport source (output valid, output cmd, output address, output data, input ready);
  modport sink   (input valid, input cmd, input address, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/abbf_out_if.sv
// ============================================================================
// abbf_out_if - output byte channel
// Valid/ready channel carrying one stream byte with its last and status flags.
// ============================================================================
`default_nettype none

interface abbf_out_if;
  logic                          valid;
  logic                          ready;
  logic [abbf_pkg::BYTE_W-1:0]   out_byte;
  logic                          last;
  logic                          status;

  modport source (output valid, output out_byte, output last, output status, input ready);
  modport sink   (input valid, input out_byte, input last, input status, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/absolute_binary_block_framer_top.sv
// ============================================================================
// absolute_binary_block_framer_top - absolute binary tape block framer
// Groups ascending address/data entries into framed blocks and streams bytes.
// ============================================================================
// Takes one item at a time and is not ready until all its bytes have gone
// into the output register. A data entry that only joins the pending block
// passes through accept, decide and append. Each data block that is written
// out first works out its checksum on the shared adder in S_SUM0 to S_SUM3
// (a start block from S_SUM1), then loads its bytes into the output
// register: 10 header bytes and 2 bytes per buffered word. An address not
// above the last appended one gives one error byte (status set) and leaves
// the state untouched. An end command writes out the pending block, for
// command 1 adds a start block, and clears the framer. Bytes wait in a
// single output register; while the sink stalls with a byte held there the
// sequencer holds in its byte states.
// ============================================================================
`default_nettype none

module absolute_binary_block_framer_top #(
  parameter int MAX_BLOCK_WORDS = abbf_pkg::MAX_BLOCK_WORDS
) (
  input  logic            clk,
  input  logic            rst,
  abbf_in_if.sink         in_ch,
  abbf_out_if.source      out_ch
);
  import abbf_pkg::*;

  // Buffer index and word count widths
  localparam int IW = (MAX_BLOCK_WORDS > 1) ? $clog2(MAX_BLOCK_WORDS) : 1;
  localparam int CW = $clog2(MAX_BLOCK_WORDS + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_SUM0   = 4'd2;
  localparam logic [3:0] S_SUM1   = 4'd3;
  localparam logic [3:0] S_SUM2   = 4'd4;
  localparam logic [3:0] S_SUM3   = 4'd5;
  localparam logic [3:0] S_HDR    = 4'd6;
  localparam logic [3:0] S_DATA   = 4'd7;
  localparam logic [3:0] S_APPEND = 4'd8;
  localparam logic [3:0] S_ERR    = 4'd9;

  // Segment being written out
  localparam logic [1:0] SEG_F1    = 2'd0;  // pending block before the entry
  localparam logic [1:0] SEG_F2    = 2'd1;  // block filled by the entry
  localparam logic [1:0] SEG_START = 2'd2;  // start block of an end command

  logic [3:0]        state;
  logic [1:0]        seg;
  logic              more;     // another segment follows the first flush
  logic              f2;       // entry fills the buffer after appending

  // Latched item
  logic [CMD_W-1:0]  cmd_q;
  logic [WORD_W-1:0] addr_q;
  logic [WORD_W-1:0] data_q;

  // Framing state
  logic [CW-1:0]     count;
  logic [WORD_W-1:0] blk_addr;
  logic [WORD_W-1:0] blk_sum;
  logic [WORD_W-1:0] prev_addr;
  logic              have_prev;

  // Header work registers
  logic [WORD_W-1:0] hcw;      // count word
  logic [WORD_W-1:0] acc;      // running sum, then checksum
  logic [HIDX_W-1:0] hidx;
  logic [IW-1:0]     widx;
  logic [IW-1:0]     widx_next;
  logic              bsel;

  // Output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_status_q;

  // Shared adder
  alu_op_t           alu_op;
  logic [WORD_W-1:0] alu_a;
  logic [WORD_W-1:0] alu_b;
  logic [WORD_W-1:0] alu_y;

  // Buffer ports
  logic              wr_en;
  logic [WORD_W-1:0] rd_data;

  logic              accept;
  logic              out_free;
  logic              order_bad;
  logic              flush1;
  logic              f2_calc;
  logic [CW-1:0]     base_count;
  logic              word_end;
  logic [WORD_W-1:0] haddr;
  logic [WORD_W-1:0] hsum;
  logic [BYTE_W-1:0] hdr_byte;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic              emit_status;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;

  assign in_ch.ready     = (state == S_IDLE);
  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.last     = out_last_q;
  assign out_ch.status   = out_status_q;

  // Header operands: a start block carries the command address and no data
  assign haddr = (seg == SEG_START) ? addr_q : blk_addr;
  assign hsum  = (seg == SEG_START) ? '0 : blk_sum;

  // Decision terms, valid in S_DEC where the adder gives previous + 1
  assign order_bad  = have_prev && (addr_q <= prev_addr);
  assign flush1     = (count != '0) && (addr_q != alu_y);
  assign base_count = flush1 ? '0 : count;
  assign f2_calc    = (base_count >= CW'(MAX_BLOCK_WORDS - 1));

  assign word_end = (CW'(widx) == (count - CW'(1)));

  // Operand select for the shared adder
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state)
      S_DEC: begin
        alu_op = ALU_INC;
        alu_a  = prev_addr;
      end
      S_SUM0: begin
        alu_op = ALU_NEG;
        alu_a  = WORD_W'(count);
      end
      S_SUM1: begin
        alu_a = hcw;
        alu_b = haddr;
      end
      S_SUM2: begin
        alu_a = acc;
        alu_b = hsum;
      end
      S_SUM3: begin
        alu_op = ALU_NEG;
        alu_a  = acc;
      end
      S_APPEND: begin
        alu_a = blk_sum;
        alu_b = data_q;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  abbf_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // Header byte select
  always_comb begin
    if (hidx < HIDX_W'(LEAD_ZEROS)) begin
      hdr_byte = '0;
    end else begin
      unique case (hidx)
        HIDX_W'(4): hdr_byte = hcw[7:0];
        HIDX_W'(5): hdr_byte = hcw[15:8];
        HIDX_W'(6): hdr_byte = haddr[7:0];
        HIDX_W'(7): hdr_byte = haddr[15:8];
        HIDX_W'(8): hdr_byte = acc[7:0];
        HIDX_W'(9): hdr_byte = acc[15:8];
        default:    hdr_byte = '0;
      endcase
    end
  end

  // Byte to load into the output register this cycle
  always_comb begin
    emit        = 1'b0;
    emit_byte   = '0;
    emit_last   = 1'b0;
    emit_status = STATUS_OK;
    unique case (state)
      S_HDR: begin
        emit      = out_free;
        emit_byte = hdr_byte;
        emit_last = (seg == SEG_START) && (hidx == HDR_LAST);
      end
      S_DATA: begin
        emit      = out_free;
        emit_byte = bsel ? rd_data[15:8] : rd_data[7:0];
        emit_last = bsel && word_end && ((seg == SEG_F2) || !more);
      end
      S_ERR: begin
        emit        = out_free;
        emit_last   = 1'b1;
        emit_status = STATUS_ORDER;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Buffer read address uses the next index, so the registered word is ready on entry
  always_comb begin
    widx_next = widx;
    if (state == S_HDR) begin
      widx_next = '0;
    end else if ((state == S_DATA) && out_free && bsel && !word_end) begin
      widx_next = IW'(widx + 1'b1);
    end
  end

  assign wr_en = (state == S_APPEND);

  abbf_buf #(
    .DEPTH (MAX_BLOCK_WORDS),
    .IW    (IW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[IW-1:0]),
    .wr_data (data_q),
    .rd_addr (widx_next),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    widx <= widx_next;
    if (accept) begin
      cmd_q  <= in_ch.cmd;
      addr_q <= in_ch.address;
      data_q <= in_ch.data;
    end
    if (emit) begin
      out_byte_q   <= emit_byte;
      out_last_q   <= emit_last;
      out_status_q <= emit_status;
    end
  end

  // Sequencer and framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg       <= SEG_F1;
      more      <= 1'b0;
      f2        <= 1'b0;
      hidx      <= '0;
      bsel      <= 1'b0;
      count     <= '0;
      blk_addr  <= '0;
      blk_sum   <= '0;
      prev_addr <= '0;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DEC;
          end
        end

        S_DEC: begin
          if (cmd_q == CMD_DATA) begin
            if (order_bad) begin
              state <= S_ERR;
            end else begin
              f2    <= f2_calc;
              more  <= f2_calc;
              if (flush1) begin
                seg   <= SEG_F1;
                state <= S_SUM0;
              end else begin
                state <= S_APPEND;
              end
            end
          end else if ((cmd_q == CMD_START) || (cmd_q == CMD_END)) begin
            more <= (cmd_q == CMD_START);
            if (count != '0) begin
              seg   <= SEG_F1;
              state <= S_SUM0;
            end else if (cmd_q == CMD_START) begin
              seg   <= SEG_START;
              hcw   <= WORD_W'(1);
              state <= S_SUM1;
            end else begin
              // nothing pending: clear and finish silently
              blk_addr  <= '0;
              prev_addr <= '0;
              have_prev <= 1'b0;
              blk_sum   <= '0;
              state     <= S_IDLE;
            end
          end else begin
            // unused command: drop
            state <= S_IDLE;
          end
        end

        S_SUM0: begin
          hcw   <= alu_y;
          state <= S_SUM1;
        end

        S_SUM1: begin
          acc   <= alu_y;
          state <= S_SUM2;
        end

        S_SUM2: begin
          acc   <= alu_y;
          state <= S_SUM3;
        end

        S_SUM3: begin
          acc   <= alu_y;
          hidx  <= '0;
          state <= S_HDR;
        end

        S_HDR: begin
          if (out_free) begin
            if (hidx == HDR_LAST) begin
              if (seg == SEG_START) begin
                count     <= '0;
                blk_addr  <= '0;
                blk_sum   <= '0;
                prev_addr <= '0;
                have_prev <= 1'b0;
                state     <= S_IDLE;
              end else begin
                bsel  <= 1'b0;
                state <= S_DATA;
              end
            end else begin
              hidx <= HIDX_W'(hidx + 1'b1);
            end
          end
        end

        S_DATA: begin
          if (out_free) begin
            if (!bsel) begin
              bsel <= 1'b1;
            end else begin
              bsel <= 1'b0;
              if (word_end) begin
                // block written out: empty the buffer
                count   <= '0;
                blk_sum <= '0;
                if (seg == SEG_F2) begin
                  state <= S_IDLE;
                end else if (cmd_q == CMD_DATA) begin
                  state <= S_APPEND;
                end else if (cmd_q == CMD_START) begin
                  seg   <= SEG_START;
                  hcw   <= WORD_W'(1);
                  state <= S_SUM1;
                end else begin
                  blk_addr  <= '0;
                  prev_addr <= '0;
                  have_prev <= 1'b0;
                  state     <= S_IDLE;
                end
              end
            end
          end
        end

        S_APPEND: begin
          count     <= CW'(count + 1'b1);
          blk_sum   <= alu_y;
          prev_addr <= addr_q;
          have_prev <= 1'b1;
          if (count == '0) begin
            blk_addr <= addr_q;
          end
          if (f2) begin
            seg   <= SEG_F2;
            state <= S_SUM0;
          end else begin
            state <= S_IDLE;
          end
        end

        S_ERR: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The buffer never holds more words than a block allows
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BLOCK_WORDS))
    else $error("block word count above maximum");

  // An accepted item always goes to the decision step next
  a_accept_dec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DEC) && !in_ch.ready)
    else $error("accepted item not decided");

  // Word reads stay within the buffered words
  a_widx_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DATA) |-> (CW'(widx) < count))
    else $error("buffer read beyond pending words");

  // An error result is always the only and last result of its item
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status_q) |-> (out_last_q && (out_byte_q == '0)))
    else $error("error result without last flag");

endmodule

`default_nettype wire

FILE: hw/rtl/abbf_alu.sv
// ============================================================================
// abbf_alu - shared 16-bit arithmetic unit
// Add, increment or negate; reused by the sequencer for every sum.
// ============================================================================
`default_nettype none

module abbf_alu (
  input  abbf_pkg::alu_op_t            op,
  input  logic [abbf_pkg::WORD_W-1:0]  a,
  input  logic [abbf_pkg::WORD_W-1:0]  b,
  output logic [abbf_pkg::WORD_W-1:0]  y
);
  import abbf_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: y = a + b;
      ALU_INC: y = a + WORD_W'(1);
      ALU_NEG: y = ~a + WORD_W'(1);
      default: y = a;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/abbf_buf.sv
// ============================================================================
// abbf_buf - block word buffer
// One write port, one registered read port.
// ============================================================================
`default_nettype none

module abbf_buf #(
  parameter int DEPTH = abbf_pkg::MAX_BLOCK_WORDS,
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IW-1:0]                wr_addr,
  input  logic [abbf_pkg::WORD_W-1:0]  wr_data,
  input  logic [IW-1:0]                rd_addr,
  output logic [abbf_pkg::WORD_W-1:0]  rd_data
);
  import abbf_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
